// ===== rtl/cld_pkg.sv =====
package cld_pkg;

    // Port widths fixed by the item layouts.
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 1;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_ACCEPT_KEYS     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CANONICAL_MODE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SIGNALS_ENABLED = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ECHO_ENABLED    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ECHO_CONTROL    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERRUPT_CHAR  = 3'd5;

    localparam logic [7:0] INTERRUPT_CHAR_RESET = 8'h03;

    // Input item kinds.
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Result item kinds.
    localparam logic [1:0] RES_NONE      = 2'd0;
    localparam logic [1:0] RES_ECHO      = 2'd1;
    localparam logic [1:0] RES_READ      = 2'd2;
    localparam logic [1:0] RES_NOT_READY = 2'd3;

    // Character codes.
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_CTRL_L    = 8'h0C;
    localparam logic [7:0] CHAR_ESC       = 8'h1B;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_TWO       = 8'h32;
    localparam logic [7:0] CHAR_J         = 8'h4A;
    localparam logic [7:0] CHAR_CARET     = 8'h5E;
    localparam logic [7:0] CTRL_OFFSET    = 8'h40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_FETCH,
        ST_EMIT
    } cld_state_t;

    typedef enum logic [2:0] {
        PL_NONE,
        PL_NOT_READY,
        PL_CLEAR,
        PL_CARET,
        PL_ECHO,
        PL_READ
    } cld_plan_t;

    // Controller to datapath.
    typedef struct packed {
        logic look;    // sample the last stored byte
        logic take;    // capture the input item
        logic decide;  // commit the state update and the result plan
        logic fetch;   // read the next byte of a read request
        logic push;    // load the next result into the output register
    } cld_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic dec_read;   // plan being decided streams read bytes
        logic plan_read;  // current plan streams read bytes
        logic slot_free;  // output register can take a result
        logic last_step;  // current result is the last of the item
    } cld_sts_t;

    // Screen clear sequence: ESC [ 2 J.
    function automatic logic [7:0] clear_seq(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CHAR_ESC;
            2'd1:    b = CHAR_LBRACKET;
            2'd2:    b = CHAR_TWO;
            default: b = CHAR_J;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/cld_ctrl.sv =====
module cld_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output cld_pkg::cld_cmd_t cmd,
    input  cld_pkg::cld_sts_t sts
);
    import cld_pkg::*;

    cld_state_t state_reg;
    cld_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = sts.dec_read ? ST_FETCH : ST_EMIT;
            end
            ST_FETCH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.slot_free) begin
                    if (sts.last_step) begin
                        state_next = ST_IDLE;
                    end else if (sts.plan_read) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.look = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
            end
            ST_FETCH: begin
                cmd.fetch = 1'b1;
            end
            ST_EMIT: begin
                cmd.push = sts.slot_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/cld_datapath.sv =====
module cld_datapath #(
    parameter int BUFFER_BYTES = 128,
    parameter int MAX_READ     = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [cld_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [cld_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                            cfg_we,
    input  logic [cld_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cld_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cld_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [cld_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast,
    input  cld_pkg::cld_cmd_t               cmd,
    output cld_pkg::cld_sts_t               sts
);
    import cld_pkg::*;

    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int RW = $clog2(MAX_READ + 1);
    localparam int NW = (RW > 3) ? RW : 3;
    localparam int CW = (FW > 7) ? FW : 7;

    // Configuration.
    logic       accept_keys_reg;
    logic       canonical_mode_reg;
    logic       signals_enabled_reg;
    logic       echo_enabled_reg;
    logic       echo_control_reg;
    logic [7:0] interrupt_char_reg;

    // Captured input item.
    logic       kind_reg;
    logic [7:0] key_reg;
    logic       ctrl_reg;
    logic       alt_reg;
    logic [6:0] count_reg;

    // Line state.
    logic [FW-1:0] fill_end_reg;
    logic [FW-1:0] read_start_reg;
    logic          reader_waiting_reg;
    logic [7:0]    line_store [BUFFER_BYTES];
    logic [7:0]    rd_data_reg;

    // Result plan.
    cld_plan_t     plan_reg;
    logic [7:0]    byte_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] step_reg;
    logic          intr_reg;
    logic          wake_reg;
    logic [AW-1:0] rd_ptr_reg;

    // Output register.
    logic       m_tvalid_reg;
    logic [1:0] kind_out_reg;
    logic [7:0] byte_out_reg;
    logic       intr_out_reg;
    logic       wake_out_reg;
    logic       last_out_reg;

    // Decode.
    logic          fold;
    logic          mod_drop;
    logic [7:0]    c_key;
    logic          ready;
    logic [FW-1:0] fe_dec;
    logic [FW-1:0] avail;
    logic [6:0]    req_sat;
    logic [CW-1:0] req_ext;
    logic [CW-1:0] avail_ext;
    logic [NW-1:0] cnt;
    logic [FW:0]   rs_sum;
    cld_plan_t     plan_d;
    logic [NW-1:0] n_d;
    logic          intr_d;
    logic          wake_d;
    logic          wr_en_d;
    logic [FW-1:0] fill_end_d;
    logic [FW-1:0] read_start_d;
    logic          waiting_d;
    logic [AW-1:0] rd_addr;
    logic [1:0]    res_kind;
    logic [7:0]    res_byte;
    logic          last_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accept_keys_reg     <= 1'b1;
            canonical_mode_reg  <= 1'b1;
            signals_enabled_reg <= 1'b1;
            echo_enabled_reg    <= 1'b1;
            echo_control_reg    <= 1'b1;
            interrupt_char_reg  <= INTERRUPT_CHAR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ACCEPT_KEYS:     accept_keys_reg     <= cfg_data[0];
                REG_CANONICAL_MODE:  canonical_mode_reg  <= cfg_data[0];
                REG_SIGNALS_ENABLED: signals_enabled_reg <= cfg_data[0];
                REG_ECHO_ENABLED:    echo_enabled_reg    <= cfg_data[0];
                REG_ECHO_CONTROL:    echo_control_reg    <= cfg_data[0];
                REG_INTERRUPT_CHAR:  interrupt_char_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            kind_reg  <= s_tuser[0];
            key_reg   <= s_tdata[7:0];
            ctrl_reg  <= s_tdata[8];
            alt_reg   <= s_tdata[9];
            count_reg <= s_tdata[16:10];
        end
    end

    // Key folding, readiness and read byte count.
    always_comb begin
        fold     = ctrl_reg && !alt_reg && (key_reg[7:6] == 2'b01);
        c_key    = fold ? {3'b000, key_reg[4:0]} : key_reg;
        mod_drop = (ctrl_reg && !fold) || alt_reg;
        fe_dec   = fill_end_reg - FW'(1);
        ready    = (fill_end_reg != '0) &&
                   (!canonical_mode_reg || (rd_data_reg == CHAR_NEWLINE));
        avail    = (fill_end_reg > read_start_reg) ? (fill_end_reg - read_start_reg) : '0;
        req_sat  = (count_reg > 7'(MAX_READ)) ? 7'(MAX_READ) : count_reg;
        req_ext  = CW'(req_sat);
        avail_ext = CW'(avail);
        cnt      = (req_ext < avail_ext) ? NW'(req_ext) : NW'(avail_ext);
        rs_sum   = {1'b0, read_start_reg} + (FW + 1)'(cnt);
    end

    // Per-item decision: state update and which results to give.
    always_comb begin
        plan_d       = PL_NONE;
        n_d          = NW'(1);
        intr_d       = 1'b0;
        wake_d       = 1'b0;
        wr_en_d      = 1'b0;
        fill_end_d   = fill_end_reg;
        read_start_d = read_start_reg;
        waiting_d    = reader_waiting_reg;
        if (kind_reg == KIND_READ) begin
            if (!ready) begin
                waiting_d = 1'b1;
                plan_d    = PL_NOT_READY;
            end else begin
                waiting_d = 1'b0;
                if (cnt == '0) begin
                    plan_d = PL_NOT_READY;
                end else begin
                    plan_d = PL_READ;
                    n_d    = cnt;
                end
                if (rs_sum >= {1'b0, fill_end_reg}) begin
                    read_start_d = '0;
                    fill_end_d   = '0;
                end else begin
                    read_start_d = rs_sum[FW-1:0];
                end
            end
        end else if (!accept_keys_reg || mod_drop) begin
            plan_d = PL_NONE;
        end else if (canonical_mode_reg && (c_key == CHAR_CTRL_L)) begin
            plan_d = PL_CLEAR;
            n_d    = NW'(4);
        end else if (signals_enabled_reg && (c_key != 8'h00) &&
                     (c_key == interrupt_char_reg)) begin
            intr_d = 1'b1;
            if (echo_control_reg) begin
                plan_d = PL_CARET;
                n_d    = NW'(2);
            end
        end else if (canonical_mode_reg && ready) begin
            plan_d = PL_NONE;
        end else if (canonical_mode_reg && (c_key == CHAR_BACKSPACE)) begin
            if (fill_end_reg != '0) begin
                fill_end_d = fe_dec;
                plan_d     = echo_enabled_reg ? PL_ECHO : PL_NONE;
            end
        end else if (fill_end_reg < FW'(BUFFER_BYTES)) begin
            wr_en_d    = 1'b1;
            fill_end_d = fill_end_reg + FW'(1);
            plan_d     = echo_enabled_reg ? PL_ECHO : PL_NONE;
            wake_d     = reader_waiting_reg &&
                         (!canonical_mode_reg || (c_key == CHAR_NEWLINE));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_end_reg       <= '0;
            read_start_reg     <= '0;
            reader_waiting_reg <= 1'b0;
        end else if (cmd.decide) begin
            fill_end_reg       <= fill_end_d;
            read_start_reg     <= read_start_d;
            reader_waiting_reg <= waiting_d;
        end
    end

    // Line store: one write port, one registered read port.
    assign rd_addr = cmd.fetch ? rd_ptr_reg : fe_dec[AW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.decide && wr_en_d) begin
            line_store[fill_end_reg[AW-1:0]] <= c_key;
        end
        if (cmd.look || cmd.fetch) begin
            rd_data_reg <= line_store[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            plan_reg   <= plan_d;
            byte_reg   <= c_key;
            n_reg      <= n_d;
            step_reg   <= '0;
            intr_reg   <= intr_d;
            wake_reg   <= wake_d;
            rd_ptr_reg <= read_start_reg[AW-1:0];
        end else if (cmd.push) begin
            step_reg   <= step_reg + NW'(1);
            rd_ptr_reg <= rd_ptr_reg + AW'(1);
        end
    end

    always_comb begin
        res_kind = RES_NONE;
        res_byte = 8'h00;
        case (plan_reg)
            PL_NONE: begin
                res_kind = RES_NONE;
            end
            PL_NOT_READY: begin
                res_kind = RES_NOT_READY;
            end
            PL_CLEAR: begin
                res_kind = RES_ECHO;
                res_byte = clear_seq(step_reg[1:0]);
            end
            PL_CARET: begin
                res_kind = RES_ECHO;
                res_byte = (step_reg == '0) ? CHAR_CARET : (byte_reg + CTRL_OFFSET);
            end
            PL_ECHO: begin
                res_kind = RES_ECHO;
                res_byte = byte_reg;
            end
            PL_READ: begin
                res_kind = RES_READ;
                res_byte = rd_data_reg;
            end
            default: begin
                res_kind = RES_NONE;
            end
        endcase
    end

    assign last_step = ((step_reg + NW'(1)) == n_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.push) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            kind_out_reg <= res_kind;
            byte_out_reg <= res_byte;
            intr_out_reg <= last_step && intr_reg;
            wake_out_reg <= last_step && wake_reg;
            last_out_reg <= last_step;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, wake_out_reg, intr_out_reg, byte_out_reg};
    assign m_tuser  = kind_out_reg;
    assign m_tlast  = last_out_reg;

    assign sts.dec_read  = (plan_d == PL_READ);
    assign sts.plan_read = (plan_reg == PL_READ);
    assign sts.slot_free = !m_tvalid_reg || m_tready;
    assign sts.last_step = last_step;

endmodule

// ===== rtl/canonical_line_discipline.sv =====
// Keyboard line buffer with echo and reads. Key items (tuser kind 0) are
// folded, checked for screen clear, interrupt and erase, and stored in the
// line store while there is room; read items (kind 1) return up to
// read_count bytes once input is ready, or a single not-ready result. Each
// input item gives one or more result items, the final one marked by tlast;
// the interrupt and wake flags ride on that final item only. One item is
// handled at a time; a key item gives 1 to 4 results and a read of n bytes
// gives n results. Each read byte is preceded by a fetch step because the
// line store has a single read port with registered data. The result
// register lets the last result of an item wait for the downstream side
// while the next item is already accepted. Configuration registers are
// written through the plain write port and must only change while no item
// is in flight.
module canonical_line_discipline #(
    parameter int BUFFER_BYTES = 128,
    parameter int MAX_READ     = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] key_code, [8] ctrl_held, [9] alt_held, [16:10] read_count
    input  logic [cld_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] kind
    input  logic [cld_pkg::S_TUSER_W-1:0]   s_tuser,
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] data_byte, [8] raise_interrupt, [9] wake_reader
    output logic [cld_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] result_kind
    output logic [cld_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast,
    // Configuration writes.
    input  logic                            cfg_we,
    input  logic [cld_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [cld_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cld_pkg::*;

    cld_cmd_t cmd;
    cld_sts_t sts;

    // The controller sequences each item: capture, decide, then one result
    // per step, with an extra memory fetch step before each read byte.
    cld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // The datapath holds the configuration, the line store and its
    // indices, the result plan and the output register.
    cld_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_READ     (MAX_READ)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// ===== rtl/cld_checker.sv =====
module cld_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cld_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [cld_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import cld_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // No new item is taken while a non-final result of an item is pending.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input ready while an item is unfinished");

    // Interrupt and wake flags appear on the final result only.
    a_flags_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[9:8] == 2'b00))
        else $error("flag set on a non-final result");

    // Results without a byte carry a zero byte.
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && ((m_tuser == RES_NONE) || (m_tuser == RES_NOT_READY)))
        |-> (m_tdata[7:0] == 8'h00))
        else $error("nonzero byte on a byteless result");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
        (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind canonical_line_discipline cld_checker u_cld_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
